[rtl/srp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Shelf rectangle packer package
// Shared widths, codes, payload records and box-size rounding.
// ---------------------------------------------------------------------------
package srp_pkg;

   localparam int COORD_W    = 12;
   localparam int CANVAS_W   = 13;
   localparam int TOP_W      = 16;
   localparam int XPOS_W     = 18;
   localparam int XSUM_W     = XPOS_W + 1;
   localparam int BOX_LOG2   = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CANVAS_W-1:0] CANVAS_RESET = 13'd256;
   localparam logic [CANVAS_W-1:0] LEFT_MAX     = 13'h1FFF;
   localparam logic [TOP_W-1:0]    TOP_MAX      = 16'hFFFF;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CANVAS_WIDTH = 2'd0,
      CSR_ALIGN_MODE   = 2'd1,
      CSR_START_TOP    = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PRE_READ,
      S_PRE_FLUSH,
      S_INSERT,
      S_POST_READ,
      S_POST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic [COORD_W-1:0] from_left;
      logic [COORD_W-1:0] from_top;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
   } slot_type;

   typedef struct packed {
      logic [COORD_W-1:0] from_left;
      logic [COORD_W-1:0] from_top;
      logic [COORD_W-1:0] frame_width;
      logic [COORD_W-1:0] frame_height;
      logic               break_after;
      logic               last_frame;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0]  src_left;
      logic [COORD_W-1:0]  src_top;
      logic [CANVAS_W-1:0] to_left;
      logic [TOP_W-1:0]    to_top;
      logic                end_of_run;
   } result_type;

   typedef struct packed {
      logic                  en;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

   typedef struct packed {
      logic take_item;
      logic read_first;
      logic emit;
      logic end_of_run;
      logic close;
      logic close_run;
      logic insert;
   } cmd_type;

   typedef struct packed {
      logic flush_pre;
      logic item_last;
      logic last_entry;
      logic out_free;
      logic row_full;
   } status_type;

   function automatic logic [CANVAS_W-1:0] box_size(input logic [COORD_W-1:0] v,
                                                   input logic align);
      logic [COORD_W-BOX_LOG2:0] steps;
      steps = {1'b0, v[COORD_W-1:BOX_LOG2]} + 1'b1;
      if (align && (v[BOX_LOG2-1:0] != '0)) begin
         return {steps, {BOX_LOG2{1'b0}}};
      end
      return {1'b0, v};
   endfunction

endpackage
`default_nettype wire

[rtl/srp_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Shelf rectangle packer channels
// Frame request, placement response and register write channels.
// ---------------------------------------------------------------------------
interface srp_req_if;
   import srp_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] from_left;
   logic [COORD_W-1:0] from_top;
   logic [COORD_W-1:0] frame_width;
   logic [COORD_W-1:0] frame_height;
   logic               break_after;
   logic               last_frame;
   modport source (output valid, from_left, from_top, frame_width, frame_height,
                   break_after, last_frame, input ready);
   modport sink   (input valid, from_left, from_top, frame_width, frame_height,
                   break_after, last_frame, output ready);
endinterface

interface srp_rsp_if;
   import srp_pkg::*;
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  src_left;
   logic [COORD_W-1:0]  src_top;
   logic [CANVAS_W-1:0] to_left;
   logic [TOP_W-1:0]    to_top;
   logic                end_of_run;
   modport source (output valid, src_left, src_top, to_left, to_top, end_of_run,
                   input ready);
   modport sink   (input valid, src_left, src_top, to_left, to_top, end_of_run,
                   output ready);
endinterface

interface srp_csr_if;
   import srp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

[rtl/srp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Shelf rectangle packer controller
// Sequences accept, row replay, insert and end-of-run flush per frame.
// ---------------------------------------------------------------------------
module srp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  srp_pkg::status_type status,
   output srp_pkg::cmd_type    cmd
);
   import srp_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = status.flush_pre ? S_PRE_READ : S_INSERT;
            end
         end
         S_PRE_READ: begin
            cmd.read_first = 1'b1;
            state_in       = S_PRE_FLUSH;
         end
         S_PRE_FLUSH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_entry) begin
                  cmd.close      = 1'b1;
                  cmd.end_of_run = !status.item_last;
                  state_in       = S_INSERT;
               end
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = status.item_last ? S_POST_READ : S_IDLE;
         end
         S_POST_READ: begin
            cmd.read_first = 1'b1;
            state_in       = S_POST_FLUSH;
         end
         S_POST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_entry) begin
                  cmd.close      = 1'b1;
                  cmd.close_run  = 1'b1;
                  cmd.end_of_run = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/srp_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Shelf rectangle packer datapath
// Registers, row buffer memory, placement arithmetic and result register.
// ---------------------------------------------------------------------------
module srp_dpath #(
   parameter int ROW_FRAMES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  srp_pkg::cmd_type    cmd,
   output srp_pkg::status_type status,
   input  srp_pkg::item_type   req_item,
   input  srp_pkg::csr_wr_type csr_wr,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output srp_pkg::result_type rsp_data
);
   import srp_pkg::*;

   localparam int CNT_W = $clog2(ROW_FRAMES + 1);
   localparam int IDX_W = (ROW_FRAMES > 1) ? $clog2(ROW_FRAMES) : 1;

   logic [CANVAS_W-1:0] canvas_width_ff;
   logic                align_mode_ff;
   logic [COORD_W-1:0]  start_top_ff;

   logic [CNT_W-1:0]    row_count_ff,  row_count_in;
   logic [CANVAS_W-1:0] row_width_ff,  row_width_in;
   logic [CANVAS_W-1:0] row_height_ff, row_height_in;
   logic [TOP_W-1:0]    cursor_top_ff, cursor_top_in;
   logic                pending_break_ff, pending_break_in;

   item_type            item_ff;
   slot_type            rd_data_ff;
   logic [IDX_W-1:0]    k_ff;
   logic [XPOS_W-1:0]   x_ff;
   logic                rsp_valid_ff;
   result_type          rsp_data_ff;

   slot_type            row_mem [ROW_FRAMES];
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   slot_type            wr_slot;

   logic [CANVAS_W-1:0] req_bw;
   logic [CANVAS_W:0]   fit_sum;
   logic [CANVAS_W-1:0] item_bw;
   logic [CANVAS_W-1:0] item_bh;
   logic [CANVAS_W+1:0] rw_sum;
   logic [CANVAS_W-1:0] emit_bw;
   logic [COORD_W-1:0]  center_off;
   logic [XSUM_W-1:0]   nx_sum;
   logic [XSUM_W-1:0]   x_sum;
   logic [TOP_W:0]      ny_sum;
   logic [TOP_W:0]      cur_sum;
   logic [CNT_W-1:0]    k_plus;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff <= CANVAS_RESET;
         align_mode_ff   <= 1'b0;
         start_top_ff    <= '0;
      end else if (csr_wr.en) begin
         case (csr_wr.addr)
            CSR_CANVAS_WIDTH: canvas_width_ff <= csr_wr.data[CANVAS_W-1:0];
            CSR_ALIGN_MODE:   align_mode_ff   <= csr_wr.data[0];
            CSR_START_TOP:    start_top_ff    <= csr_wr.data[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // row decision from the offered frame
   always_comb begin
      req_bw           = box_size(req_item.frame_width, align_mode_ff);
      fit_sum          = (CANVAS_W+1)'(row_width_ff) + (CANVAS_W+1)'(req_bw);
      status.row_full  = row_count_ff >= CNT_W'(ROW_FRAMES);
      status.flush_pre = (row_count_ff != '0) &&
                         ((fit_sum >= (CANVAS_W+1)'(canvas_width_ff)) ||
                          pending_break_ff || status.row_full);
      status.item_last = item_ff.last_frame;
      k_plus           = CNT_W'(k_ff) + CNT_W'(1);
      status.last_entry = k_plus == row_count_ff;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_ff <= req_item;
      end
   end

   // row buffer
   always_comb begin
      wr_slot.from_left = item_ff.from_left;
      wr_slot.from_top  = item_ff.from_top;
      wr_slot.width     = item_ff.frame_width;
      wr_slot.height    = item_ff.frame_height;
      rd_en   = cmd.read_first || (cmd.emit && !status.last_entry);
      rd_addr = cmd.read_first ? '0 : k_plus[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         row_mem[row_count_ff[IDX_W-1:0]] <= wr_slot;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   // placement of the frame being replayed
   always_comb begin
      emit_bw    = box_size(rd_data_ff.width, align_mode_ff);
      center_off = (emit_bw != {1'b0, rd_data_ff.width}) ?
                   (emit_bw[CANVAS_W-1:1] - {1'b0, rd_data_ff.width[COORD_W-1:1]}) : '0;
      nx_sum     = XSUM_W'(x_ff) + XSUM_W'(center_off);
      x_sum      = XSUM_W'(x_ff) + XSUM_W'(emit_bw) + XSUM_W'(1);
      ny_sum     = (TOP_W+1)'(cursor_top_ff) +
                   (TOP_W+1)'(row_height_ff - {1'b0, rd_data_ff.height});
      cur_sum    = (TOP_W+1)'(cursor_top_ff) + (TOP_W+1)'(row_height_ff) + (TOP_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.read_first) begin
         k_ff <= '0;
         x_ff <= '0;
      end else if (cmd.emit) begin
         k_ff <= k_plus[IDX_W-1:0];
         x_ff <= x_sum[XPOS_W] ? '1 : x_sum[XPOS_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.src_left   <= rd_data_ff.from_left;
         rsp_data_ff.src_top    <= rd_data_ff.from_top;
         rsp_data_ff.to_left    <= (nx_sum > XSUM_W'(LEFT_MAX)) ?
                                   LEFT_MAX : nx_sum[CANVAS_W-1:0];
         rsp_data_ff.to_top     <= ny_sum[TOP_W] ? TOP_MAX : ny_sum[TOP_W-1:0];
         rsp_data_ff.end_of_run <= cmd.end_of_run;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // row state
   always_comb begin
      item_bw          = box_size(item_ff.frame_width, align_mode_ff);
      item_bh          = box_size(item_ff.frame_height, align_mode_ff);
      rw_sum           = (CANVAS_W+2)'(row_width_ff) + (CANVAS_W+2)'(item_bw) +
                         (CANVAS_W+2)'(1);
      row_count_in     = row_count_ff;
      row_width_in     = row_width_ff;
      row_height_in    = row_height_ff;
      cursor_top_in    = cursor_top_ff;
      pending_break_in = pending_break_ff;
      if (cmd.insert) begin
         row_count_in     = row_count_ff + CNT_W'(1);
         row_width_in     = (rw_sum > (CANVAS_W+2)'(LEFT_MAX)) ?
                            LEFT_MAX : rw_sum[CANVAS_W-1:0];
         row_height_in    = (item_bh > row_height_ff) ? item_bh : row_height_ff;
         pending_break_in = item_ff.break_after;
      end
      if (cmd.close) begin
         row_count_in  = '0;
         row_width_in  = '0;
         row_height_in = '0;
         if (cmd.close_run) begin
            cursor_top_in    = TOP_W'(start_top_ff);
            pending_break_in = 1'b0;
         end else begin
            cursor_top_in = cur_sum[TOP_W] ? TOP_MAX : cur_sum[TOP_W-1:0];
         end
      end
      if (csr_wr.en && (csr_wr.addr == CSR_START_TOP)) begin
         cursor_top_in = TOP_W'(csr_wr.data[COORD_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff     <= '0;
         row_width_ff     <= '0;
         row_height_ff    <= '0;
         cursor_top_ff    <= '0;
         pending_break_ff <= 1'b0;
      end else begin
         row_count_ff     <= row_count_in;
         row_width_ff     <= row_width_in;
         row_height_ff    <= row_height_in;
         cursor_top_ff    <= cursor_top_in;
         pending_break_ff <= pending_break_in;
      end
   end

endmodule
`default_nettype wire

[rtl/shelf_rectangle_packer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Shelf rectangle packer
// Next-fit shelf placement of sprite frames on a canvas of set width.
//
//   channel  dir  payload                                          transfer
//   req_port in   from_left from_top frame_width frame_height       valid & ready
//                 break_after last_frame
//   rsp_port out  src_left src_top to_left to_top end_of_run        valid & ready
//   csr_port in   addr data (0 canvas_width, 1 align_mode,          valid & ready
//                 2 start_top)
//
// A frame that closes no row goes from accept to insert. Closing a row first
// starts a read of the single-port row buffer, then replays its frames, one
// result per cycle while rsp_port takes them. A last_frame also replays its row.
// Reset is synchronous; the row buffer holds no reset value.
// A stalled rsp_port holds the replay; csr_port is always ready.
// ---------------------------------------------------------------------------
module shelf_rectangle_packer #(
   parameter int ROW_FRAMES = 32
) (
   input logic        clock,
   input logic        reset,
   srp_req_if.sink    req_port,
   srp_rsp_if.source  rsp_port,
   srp_csr_if.sink    csr_port
);
   import srp_pkg::*;

   cmd_type    cmd;
   status_type status;
   item_type   req_item;
   csr_wr_type csr_wr;
   result_type rsp_data;
   logic       rsp_valid;
   logic       req_ready;

   assign req_item.from_left    = req_port.from_left;
   assign req_item.from_top     = req_port.from_top;
   assign req_item.frame_width  = req_port.frame_width;
   assign req_item.frame_height = req_port.frame_height;
   assign req_item.break_after  = req_port.break_after;
   assign req_item.last_frame   = req_port.last_frame;
   assign req_port.ready        = req_ready;

   assign csr_port.ready = 1'b1;
   assign csr_wr.en      = csr_port.valid;
   assign csr_wr.addr    = csr_port.addr;
   assign csr_wr.data    = csr_port.data;

   assign rsp_port.valid      = rsp_valid;
   assign rsp_port.src_left   = rsp_data.src_left;
   assign rsp_port.src_top    = rsp_data.src_top;
   assign rsp_port.to_left    = rsp_data.to_left;
   assign rsp_port.to_top     = rsp_data.to_top;
   assign rsp_port.end_of_run = rsp_data.end_of_run;

   srp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   srp_dpath #(
      .ROW_FRAMES (ROW_FRAMES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .csr_wr    (csr_wr),
      .rsp_ready (rsp_port.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded over an untaken result");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !status.row_full)
      else $error("frame inserted into a full row");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_port.valid)
      else $error("replayed frame not presented");

   a_close_last: assert property (@(posedge clock) disable iff (reset)
      cmd.close |-> (cmd.emit && status.last_entry))
      else $error("row closed before its last frame");

endmodule
`default_nettype wire
